>>> rtl/core/rpps_pkg.sv
// Package for the ramped PI position servo: configuration and stage beat types,
// register index codes, reset values and fixed-point constants.
// No dependencies.
package rpps_pkg;

	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] CFG_ANGLE_OFFSET = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_P_GAIN       = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_I_GAIN       = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PI_ENABLE    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_PWM_LIMIT    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_RAMP_PERIOD  = 3'd5;

	localparam logic [15:0] P_GAIN_RESET      = 16'd2048;
	localparam logic [15:0] I_GAIN_RESET      = 16'd410;
	localparam logic [6:0]  PWM_LIMIT_RESET   = 7'd60;
	localparam logic [9:0]  RAMP_PERIOD_RESET = 10'd30;

	// 0.004 / 2 in Q16.16
	localparam logic signed [8:0] INT_STEP_Q16 = 9'sd131;

	localparam logic [6:0] SETTLE_MAX         = 7'd127;
	localparam logic [6:0] DRIVE_SETTLE_TICKS = 7'd20;
	localparam logic [6:0] POS_SETTLE_TICKS   = 7'd80;
	localparam logic signed [16:0] POS_BAND   = 17'sd2;

	localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

	typedef struct packed {
		logic signed [15:0] angle_offset;
		logic [15:0]        p_gain;
		logic [15:0]        i_gain;
		logic               pi_enable;
		logic [6:0]         pwm_limit;
		logic [9:0]         ramp_period;
	} cfg_t;

	typedef struct packed {
		logic signed [16:0] err;
		logic signed [31:0] acc;
		logic signed [15:0] setpoint;
		logic               pos_settled;
	} front_beat_t;

	typedef struct packed {
		logic signed [32:0] p_prod;
		logic signed [47:0] i_prod;
		logic signed [15:0] setpoint;
		logic               pos_settled;
	} mult_beat_t;

endpackage

>>> rtl/core/rpps_front.sv
// Front end of the servo: input register, setpoint ramp, error, integral and
// position settle state, and the register that feeds the multipliers.
// Depends on rpps_pkg.
module rpps_front
	import rpps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] in_meas,
	input  logic signed [15:0] in_tgt,
	input  logic               in_ramp,
	output logic               out_valid,
	input  logic               out_ready,
	output front_beat_t        out_beat
);

	logic               v_s1;
	logic signed [15:0] meas_s1;
	logic signed [15:0] tgt_s1;
	logic               ramp_s1;
	logic               v_s2;
	front_beat_t        beat_s2;

	logic signed [15:0] setpoint_q;
	logic signed [15:0] last_target_q;
	logic [9:0]         ramp_ticks_q;
	logic signed [31:0] acc_q;
	logic signed [16:0] prev_err_q;
	logic [6:0]         pos_cnt_q;

	logic               s2_free;
	logic               adv;
	logic signed [15:0] sp_base;
	logic signed [15:0] sp_step;
	logic [9:0]         ticks_next;
	logic signed [15:0] used;
	logic signed [17:0] err_raw;
	logic signed [16:0] err;
	logic signed [17:0] err_sum;
	logic signed [26:0] inc;
	logic signed [32:0] acc_sum;
	logic signed [31:0] acc_next;
	logic               err_small;
	logic signed [16:0] pos_gap;
	logic               near;
	logic [6:0]         pos_cnt_next;

	assign s2_free  = !v_s2 || out_ready;
	assign adv      = v_s1 && s2_free;
	assign in_ready = !v_s1 || adv;

	always_comb begin
		sp_base    = (tgt_s1 != last_target_q) ? meas_s1 : setpoint_q;
		sp_step    = sp_base;
		ticks_next = ramp_ticks_q;
		if (sp_base != tgt_s1) begin
			if (ramp_ticks_q >= cfg.ramp_period) begin
				sp_step    = (sp_base > tgt_s1) ? sp_base - 16'sd1 : sp_base + 16'sd1;
				ticks_next = 10'd1;
			end else begin
				ticks_next = ramp_ticks_q + 10'd1;
			end
		end
		used = ramp_s1 ? sp_step : tgt_s1;
	end

	always_comb begin
		err_raw = {{2{used[15]}}, used} + {{2{cfg.angle_offset[15]}}, cfg.angle_offset}
			- {{2{meas_s1[15]}}, meas_s1};
		if (err_raw[17] != err_raw[16]) begin
			err = err_raw[17] ? 17'sh10000 : 17'sh0FFFF;
		end else begin
			err = err_raw[16:0];
		end
		err_sum = {err[16], err} + {prev_err_q[16], prev_err_q};
		inc     = err_sum * INT_STEP_Q16;
		acc_sum = {acc_q[31], acc_q} + {{6{inc[26]}}, inc};
		if (acc_sum[32] != acc_sum[31]) begin
			acc_next = acc_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			acc_next = acc_sum[31:0];
		end
		err_small = (err == 17'sd0) || (err == 17'sd1) || (err == -17'sd1);
		if (err_small) begin
			acc_next = 32'sd0;
		end
	end

	always_comb begin
		pos_gap = {tgt_s1[15], tgt_s1} - {meas_s1[15], meas_s1};
		near    = (pos_gap >= -POS_BAND) && (pos_gap <= POS_BAND);
		if (!near) begin
			pos_cnt_next = 7'd0;
		end else if (pos_cnt_q == SETTLE_MAX) begin
			pos_cnt_next = pos_cnt_q;
		end else begin
			pos_cnt_next = pos_cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			setpoint_q    <= '0;
			last_target_q <= '0;
			ramp_ticks_q  <= '0;
			acc_q         <= '0;
			prev_err_q    <= '0;
			pos_cnt_q     <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (adv) begin
				if (ramp_s1) begin
					setpoint_q    <= sp_step;
					last_target_q <= tgt_s1;
					ramp_ticks_q  <= ticks_next;
				end
				acc_q      <= acc_next;
				prev_err_q <= err;
				pos_cnt_q  <= pos_cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_s1 <= in_meas;
			tgt_s1  <= in_tgt;
			ramp_s1 <= in_ramp;
		end
		if (adv) begin
			beat_s2.err         <= err;
			beat_s2.acc         <= acc_q;
			beat_s2.setpoint    <= used;
			beat_s2.pos_settled <= pos_cnt_next > POS_SETTLE_TICKS;
		end
	end

	assign out_valid = v_s2;
	assign out_beat  = beat_s2;

endmodule

>>> rtl/core/rpps_mult.sv
// Multiplier stage: proportional and integral products, registered.
// Depends on rpps_pkg.
module rpps_mult
	import rpps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  front_beat_t in_beat,
	output logic        out_valid,
	input  logic        out_ready,
	output mult_beat_t  out_beat
);

	logic               v_s3;
	mult_beat_t         beat_s3;
	logic signed [33:0] p_full;
	logic signed [48:0] i_full;

	assign in_ready = !v_s3 || out_ready;

	assign p_full = in_beat.err * $signed({1'b0, cfg.p_gain});
	assign i_full = in_beat.acc * $signed({1'b0, cfg.i_gain});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s3.p_prod      <= p_full[32:0];
			beat_s3.i_prod      <= cfg.pi_enable ? i_full[47:0] : 48'sd0;
			beat_s3.setpoint    <= in_beat.setpoint;
			beat_s3.pos_settled <= in_beat.pos_settled;
		end
	end

	assign out_valid = v_s3;
	assign out_beat  = beat_s3;

endmodule

>>> rtl/core/rpps_drive.sv
// Drive stage: sum of terms in Q.28, clamp to the PWM limit, truncation toward
// zero, drive settle counter and the output register. Depends on rpps_pkg.
module rpps_drive
	import rpps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  mult_beat_t        in_beat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0]  drive_pwm,
	output logic signed [15:0] current_setpoint,
	output logic              drive_settled,
	output logic              position_settled
);

	logic               v_q;
	logic [6:0]         drive_cnt_q;
	logic signed [7:0]  drive_q;
	logic signed [15:0] setpoint_q;
	logic               drive_settled_q;
	logic               pos_settled_q;

	logic               load;
	logic signed [49:0] total;
	logic signed [49:0] lim;
	logic signed [35:0] clamped;
	logic signed [35:0] biased;
	logic [6:0]         drive_cnt_next;

	assign in_ready = !v_q || out_ready;
	assign load     = in_valid && in_ready;

	always_comb begin
		total = {{1{in_beat.p_prod[32]}}, in_beat.p_prod, 16'd0}
			+ {{2{in_beat.i_prod[47]}}, in_beat.i_prod};
		lim   = {15'd0, cfg.pwm_limit, 28'd0};
		if (total > lim) begin
			clamped = lim[35:0];
		end else if (total < -lim) begin
			clamped = -lim[35:0];
		end else begin
			clamped = total[35:0];
		end
		biased = clamped + (clamped[35] ? (ONE_Q28 - 36'sd1) : 36'sd0);
		if (clamped >= ONE_Q28) begin
			drive_cnt_next = 7'd0;
		end else if (drive_cnt_q == SETTLE_MAX) begin
			drive_cnt_next = drive_cnt_q;
		end else begin
			drive_cnt_next = drive_cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= 1'b0;
			drive_cnt_q <= '0;
		end else begin
			if (in_ready) begin
				v_q <= in_valid;
			end
			if (load) begin
				drive_cnt_q <= drive_cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			drive_q         <= biased[35:28];
			setpoint_q      <= in_beat.setpoint;
			drive_settled_q <= drive_cnt_next > DRIVE_SETTLE_TICKS;
			pos_settled_q   <= in_beat.pos_settled;
		end
	end

	assign out_valid        = v_q;
	assign drive_pwm        = drive_q;
	assign current_setpoint = setpoint_q;
	assign drive_settled    = drive_settled_q;
	assign position_settled = pos_settled_q;

endmodule

>>> rtl/core/ramped_pi_position_servo_top.sv
// Top level of the ramped PI position servo: configuration registers, the
// three stages and the stream ports. Depends on rpps_pkg, rpps_front,
// rpps_mult and rpps_drive.
//
// One control tick enters per beat and its result passes four registers:
// input register, error register, product register, output register. A new
// tick is taken every cycle; each stage advances when the one after it is
// empty or moving, so a stalled output stops the input only once every stage
// holds a tick. The setpoint, integral and settle state each close within a
// single stage, which sets the one-tick per cycle rate. The user must write
// configuration only while no tick is in flight; the block does not enforce it.
module ramped_pi_position_servo_top
	import rpps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [15:0]          cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // measured_position, target_angle
	input  logic                 s_axis_tuser,  // use_ramp
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// drive_pwm, current_setpoint, drive_settled, position_settled, zero pad
	output logic [31:0]          m_axis_tdata
);

	cfg_t               cfg_q;
	logic               f_valid;
	logic               f_ready;
	front_beat_t        f_beat;
	logic               m_valid;
	logic               m_ready;
	mult_beat_t         m_beat;
	logic signed [7:0]  drive_pwm;
	logic signed [15:0] current_setpoint;
	logic               drive_settled;
	logic               position_settled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_offset <= '0;
			cfg_q.p_gain       <= P_GAIN_RESET;
			cfg_q.i_gain       <= I_GAIN_RESET;
			cfg_q.pi_enable    <= 1'b0;
			cfg_q.pwm_limit    <= PWM_LIMIT_RESET;
			cfg_q.ramp_period  <= RAMP_PERIOD_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_ANGLE_OFFSET: cfg_q.angle_offset <= cfg_wdata;
				CFG_P_GAIN:       cfg_q.p_gain       <= cfg_wdata;
				CFG_I_GAIN:       cfg_q.i_gain       <= cfg_wdata;
				CFG_PI_ENABLE:    cfg_q.pi_enable    <= cfg_wdata[0];
				CFG_PWM_LIMIT:    cfg_q.pwm_limit    <= cfg_wdata[6:0];
				CFG_RAMP_PERIOD:  cfg_q.ramp_period  <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	rpps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_meas   (s_axis_tdata[15:0]),
		.in_tgt    (s_axis_tdata[31:16]),
		.in_ramp   (s_axis_tuser),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_beat  (f_beat)
	);

	rpps_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_beat   (f_beat),
		.out_valid (m_valid),
		.out_ready (m_ready),
		.out_beat  (m_beat)
	);

	rpps_drive u_drive (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (m_valid),
		.in_ready         (m_ready),
		.in_beat          (m_beat),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.drive_pwm        (drive_pwm),
		.current_setpoint (current_setpoint),
		.drive_settled    (drive_settled),
		.position_settled (position_settled)
	);

	assign m_axis_tdata = {6'd0, position_settled, drive_settled, current_setpoint, drive_pwm};

`ifndef ASSERT_OFF
	a_drive_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (drive_pwm <= $signed({1'b0, cfg_q.pwm_limit}))
			&& (drive_pwm >= -$signed({1'b0, cfg_q.pwm_limit})))
		else $error("drive beyond pwm limit");

	a_settled_drive_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && drive_settled) |-> (drive_pwm <= 8'sd0))
		else $error("drive settled flag with positive drive");

	a_front_takes_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!f_valid && !m_valid && !m_axis_tvalid) |=> s_axis_tready)
		else $error("front stalled with empty pipeline");
`endif

endmodule
